// ===== rtl/elu_pkg.sv =====
// Shared types and constants for the eikonal local update pipeline.
// No dependencies; used by elu_root_step, eikonal_local_update and the testbench.
package elu_pkg;

   localparam int DIST_W = 24;
   localparam int COST_W = 16;

   // |a-b| only needs squaring when it is below 2*cost
   localparam int DIFF_W = COST_W + 1;
   localparam int SQ_W   = 2 * DIFF_W;

   // square root: two bit pairs per stage over a zero-padded radicand
   localparam int ROOT_W          = (SQ_W + 3) / 4 * 2;
   localparam int DISC_PAD_W      = 2 * ROOT_W;
   localparam int REM_W           = ROOT_W + 2;
   localparam int PAIRS_PER_STAGE = 2;
   localparam int ROOT_STAGES     = ROOT_W / PAIRS_PER_STAGE;
   localparam int PAIR_BITS       = 2 * PAIRS_PER_STAGE;

   // five front stages, the root stages, one output stage
   localparam int FRONT_STAGES = 5;
   localparam int NUM_STAGES   = FRONT_STAGES + ROOT_STAGES + 1;

   localparam logic [DIST_W-1:0] DIST_INF     = {DIST_W{1'b1}};
   localparam logic [DIST_W-1:0] DIST_MAX_FIN = DIST_INF - 1'b1;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } root_state_type;

   typedef struct packed {
      logic              unreach;
      logic              use_one;
      logic [DIST_W-1:0] one_res;
      logic [DIST_W:0]   sum_ab;
   } side_type;

endpackage

// ===== rtl/elu_root_step.sv =====
// Two restoring square-root iterations on one partial remainder and root.
// Depends on elu_pkg.
module elu_root_step
   import elu_pkg::*;
(
   input  root_state_type         st_i,
   input  logic [PAIR_BITS-1:0]   pairs_i,
   output root_state_type         st_o
);

   always_comb begin
      logic [REM_W-1:0]  rem;
      logic [REM_W-1:0]  trial;
      logic [ROOT_W-1:0] root;
      rem  = st_i.rem;
      root = st_i.root;
      for (int j = 0; j < PAIRS_PER_STAGE; j++) begin
         rem   = {rem[REM_W-3:0], pairs_i[PAIR_BITS-1-2*j -: 2]};
         trial = {root, 2'b01};
         if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[ROOT_W-2:0], 1'b1};
         end else begin
            root = {root[ROOT_W-2:0], 1'b0};
         end
      end
      st_o.rem  = rem;
      st_o.root = root;
   end

endmodule

// ===== rtl/eikonal_local_update.sv =====
// Top level: first-order 2-D eikonal local update, fully pipelined.
// Depends on elu_pkg and elu_root_step.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_dist_*, req_local_cost
//   rsp     | out       | rsp_valid, rsp_stall, rsp_new_distance, rsp_unreachable
//
// One item per cycle while rsp_stall is low; each item passes through the front stages,
// the square-root stages and the output stage.
// The square root produces two result bits per stage over nine stages.
// Reset clears only the stage valid bits.
// A stage loads when it is empty or the stage after it moves, so bubbles close up
// under rsp_stall; req_stall rises only when every stage holds an item.
module eikonal_local_update
   import elu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [DIST_W-1:0] req_dist_left,
   input  logic [DIST_W-1:0] req_dist_right,
   input  logic [DIST_W-1:0] req_dist_up,
   input  logic [DIST_W-1:0] req_dist_down,
   input  logic [COST_W-1:0] req_local_cost,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DIST_W-1:0] rsp_new_distance,
   output logic              rsp_unreachable
);

   localparam int LAST = NUM_STAGES - 1;

   logic [NUM_STAGES-1:0] valid_ff, valid_in, adv;

   // stage 1: neighbor minima
   logic [DIST_W-1:0] a_ff, b_ff, a_in, b_in;
   logic [COST_W-1:0] c1_ff;
   // stage 2: difference, low side, sum
   logic [DIST_W-1:0] diff_ff, lo_ff, diff_in, lo_in;
   logic [DIST_W:0]   sum_ab_ff, sum_ab_in;
   logic              a_inf_ff, b_inf_ff;
   logic [COST_W-1:0] c2_ff;
   logic [DIST_W:0]   d_ab, d_ba;
   // stage 3: wide test, one-sided result
   logic [DIFF_W-1:0] diff3_ff;
   logic [COST_W-1:0] c3_ff;
   logic              wide3_ff, wide3_in, diffnz3_ff;
   side_type          side3_ff, side3_in;
   logic [DIST_W:0]   one_sum;
   // stage 4: squares
   logic [SQ_W-1:0]     dd_ff;
   logic [2*COST_W-1:0] cc_ff;
   logic                wide4_ff, diffnz4_ff;
   side_type            side4_ff;
   // stage 5: discriminant
   logic [SQ_W-1:0] disc_ff, disc_in, twocc;
   logic [SQ_W:0]   disc_sub;
   logic            neg;
   side_type        side5_ff, side5_in;
   // root stages
   root_state_type       rs_ff   [ROOT_STAGES];
   root_state_type       rs_in   [ROOT_STAGES];
   logic [DISC_PAD_W-1:0] rdisc_ff [ROOT_STAGES];
   side_type             rside_ff [ROOT_STAGES];
   root_state_type       root_init;
   // output stage
   logic [DIST_W+1:0] tot;
   logic [DIST_W-1:0] half_sat, dist_in;
   logic [DIST_W-1:0] rsp_new_distance_ff;
   logic              rsp_unreachable_ff;

   // stall chain
   always_comb begin
      adv[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int k = LAST - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in = {valid_ff[LAST-1:0], req_valid};
   end

   assign req_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // stage 1
   assign a_in = (req_dist_left < req_dist_right) ? req_dist_left : req_dist_right;
   assign b_in = (req_dist_up < req_dist_down) ? req_dist_up : req_dist_down;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         c1_ff <= req_local_cost;
      end
   end

   // stage 2
   assign d_ab      = {1'b0, a_ff} - {1'b0, b_ff};
   assign d_ba      = {1'b0, b_ff} - {1'b0, a_ff};
   assign diff_in   = d_ab[DIST_W] ? d_ba[DIST_W-1:0] : d_ab[DIST_W-1:0];
   assign lo_in     = d_ab[DIST_W] ? a_ff : b_ff;
   assign sum_ab_in = {1'b0, a_ff} + {1'b0, b_ff};

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         diff_ff   <= diff_in;
         lo_ff     <= lo_in;
         sum_ab_ff <= sum_ab_in;
         a_inf_ff  <= (a_ff == DIST_INF);
         b_inf_ff  <= (b_ff == DIST_INF);
         c2_ff     <= c1_ff;
      end
   end

   // stage 3
   assign wide3_in = diff_ff >= {{(DIST_W-COST_W-1){1'b0}}, c2_ff, 1'b0};
   assign one_sum  = {1'b0, lo_ff} + {{(DIST_W-COST_W+1){1'b0}}, c2_ff};

   always_comb begin
      side3_in.unreach = a_inf_ff && b_inf_ff;
      side3_in.use_one = a_inf_ff || b_inf_ff;
      side3_in.one_res = (one_sum >= {1'b0, DIST_INF}) ? DIST_MAX_FIN
                                                        : one_sum[DIST_W-1:0];
      side3_in.sum_ab  = sum_ab_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         diff3_ff   <= diff_ff[DIFF_W-1:0];
         c3_ff      <= c2_ff;
         wide3_ff   <= wide3_in;
         diffnz3_ff <= (diff_ff != '0);
         side3_ff   <= side3_in;
      end
   end

   // stage 4
   always_ff @(posedge clock) begin
      if (adv[3]) begin
         dd_ff      <= diff3_ff * diff3_ff;
         cc_ff      <= c3_ff * c3_ff;
         wide4_ff   <= wide3_ff;
         diffnz4_ff <= diffnz3_ff;
         side4_ff   <= side3_ff;
      end
   end

   // stage 5
   assign twocc    = {{(SQ_W-2*COST_W-1){1'b0}}, cc_ff, 1'b0};
   assign disc_sub = {1'b0, twocc} - {1'b0, dd_ff};
   assign neg      = wide4_ff ? diffnz4_ff : disc_sub[SQ_W];
   assign disc_in  = (wide4_ff || disc_sub[SQ_W]) ? '0 : disc_sub[SQ_W-1:0];

   always_comb begin
      side5_in         = side4_ff;
      side5_in.use_one = side4_ff.use_one || neg;
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         disc_ff  <= disc_in;
         side5_ff <= side5_in;
      end
   end

   // square root stages
   assign root_init = '{rem: '0, root: '0};

   // stage-by-stage root iterations
   logic [DISC_PAD_W-1:0] disc_pad;
   assign disc_pad = {{(DISC_PAD_W-SQ_W){1'b0}}, disc_ff};

   for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_rstep
      if (s == 0) begin : g_head
         elu_root_step u_step (
            .st_i    (root_init),
            .pairs_i (disc_pad[DISC_PAD_W-1 -: PAIR_BITS]),
            .st_o    (rs_in[s])
         );
         always_ff @(posedge clock) begin
            if (adv[FRONT_STAGES]) begin
               rs_ff[s]    <= rs_in[s];
               rdisc_ff[s] <= {disc_pad[DISC_PAD_W-PAIR_BITS-1:0], {PAIR_BITS{1'b0}}};
               rside_ff[s] <= side5_ff;
            end
         end
      end else begin : g_body
         elu_root_step u_step (
            .st_i    (rs_ff[s-1]),
            .pairs_i (rdisc_ff[s-1][DISC_PAD_W-1 -: PAIR_BITS]),
            .st_o    (rs_in[s])
         );
         always_ff @(posedge clock) begin
            if (adv[FRONT_STAGES+s]) begin
               rs_ff[s]    <= rs_in[s];
               rdisc_ff[s] <= {rdisc_ff[s-1][DISC_PAD_W-PAIR_BITS-1:0],
                               {PAIR_BITS{1'b0}}};
               rside_ff[s] <= rside_ff[s-1];
            end
         end
      end
   end

   // output stage
   assign tot = {1'b0, rside_ff[ROOT_STAGES-1].sum_ab}
              + {{(DIST_W+2-ROOT_W){1'b0}}, rs_ff[ROOT_STAGES-1].root};
   assign half_sat = (tot[DIST_W+1:1] >= {1'b0, DIST_INF}) ? DIST_MAX_FIN
                                                           : tot[DIST_W:1];

   always_comb begin
      if (rside_ff[ROOT_STAGES-1].unreach) begin
         dist_in = DIST_INF;
      end else if (rside_ff[ROOT_STAGES-1].use_one) begin
         dist_in = rside_ff[ROOT_STAGES-1].one_res;
      end else begin
         dist_in = half_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[LAST]) begin
         rsp_new_distance_ff <= dist_in;
         rsp_unreachable_ff  <= rside_ff[ROOT_STAGES-1].unreach;
      end
   end

   assign rsp_valid        = valid_ff[LAST];
   assign rsp_new_distance = rsp_new_distance_ff;
   assign rsp_unreachable  = rsp_unreachable_ff;

   // checks
   a_full_on_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("input stalled while the pipeline has a free stage");

   a_unreach_inf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_unreachable) |-> (rsp_new_distance == DIST_INF))
      else $error("unreachable item without the infinity code");

   a_finite_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_unreachable) |-> (rsp_new_distance != DIST_INF))
      else $error("reachable item carries the infinity code");

   a_item_count: assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && !req_stall) && !(rsp_valid && !rsp_stall))
      |=> ($countones(valid_ff) == $past($countones(valid_ff))))
      else $error("item lost or invented inside the pipeline");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for eikonal_local_update, the 2-D eikonal pixel update.
// Holds its own arrival-distance predictor; depends on elu_pkg and the DUT only.

module testbench;
   import elu_pkg::*;

   localparam int HOLD_CYCLES  = 80;
   localparam int LIMIT_CYCLES = 300000;
   localparam int RANDOM_ITEMS = 1400;
   localparam int NUM_PROBES   = 20;

   typedef logic [DIST_W-1:0] dist_type;
   typedef logic [COST_W-1:0] cost_type;

   typedef struct packed {
      dist_type left;
      dist_type right;
      dist_type up;
      dist_type down;
      cost_type cost;
   } pixel_type;

   typedef struct packed {
      dist_type distance;
      logic     unreachable;
   } arrival_type;

   typedef struct packed {
      pixel_type   px;
      logic        known;
      arrival_type want;
   } probe_type;

   typedef enum int {ROUTE_BLOCKED, ROUTE_ONE_SIDED, ROUTE_TWO_SIDED} route_type;

   logic     clock;
   logic     reset          = 1'b1;
   logic     req_valid      = 1'b0;
   logic     req_stall;
   dist_type req_dist_left  = '0;
   dist_type req_dist_right = '0;
   dist_type req_dist_up    = '0;
   dist_type req_dist_down  = '0;
   cost_type req_local_cost = '0;
   logic     rsp_valid;
   logic     rsp_stall      = 1'b0;
   dist_type rsp_new_distance;
   logic     rsp_unreachable;

   arrival_type pending_arrivals [$];
   int          route_count [3];
   int          sent, received, mismatches, held_cycles, cycles;
   bit          tx_calm;
   bit          hold_request;

   // most rows carry their result; the rest go through the predictor
   probe_type probe_table [NUM_PROBES] = '{
      '{'{DIST_INF, DIST_INF, DIST_INF, DIST_INF, 16'h0000}, 1'b1, '{DIST_INF, 1'b1}},
      '{'{DIST_INF, DIST_INF, DIST_INF, DIST_INF, 16'hFFFF}, 1'b1, '{DIST_INF, 1'b1}},
      '{'{24'd0, 24'd0, 24'd0, 24'd0, 16'h0000}, 1'b1, '{24'd0, 1'b0}},
      '{'{24'd0, 24'd0, 24'd0, 24'd0, 16'hFFFF}, 1'b0, '{24'd0, 1'b0}},
      '{'{24'd0, DIST_INF, DIST_INF, DIST_INF, 16'hFFFF}, 1'b1, '{24'h00FFFF, 1'b0}},
      '{'{DIST_INF, 24'd5, DIST_INF, DIST_INF, 16'd3}, 1'b1, '{24'd8, 1'b0}},
      '{'{DIST_INF, DIST_INF, DIST_INF, DIST_MAX_FIN, 16'd1}, 1'b1, '{DIST_MAX_FIN, 1'b0}},
      '{'{DIST_MAX_FIN, DIST_MAX_FIN, DIST_MAX_FIN, DIST_MAX_FIN, 16'hFFFF},
        1'b1, '{DIST_MAX_FIN, 1'b0}},
      '{'{24'd0, DIST_INF, 24'd1000, DIST_INF, 16'd10}, 1'b1, '{24'd10, 1'b0}},
      '{'{DIST_INF, 24'd0, 24'd20, DIST_INF, 16'd10}, 1'b1, '{24'd10, 1'b0}},
      '{'{24'd0, 24'd0, 24'd19, 24'd19, 16'd10}, 1'b0, '{24'd0, 1'b0}},
      '{'{24'd256, 24'd300, 24'd256, 24'd400, 16'd256}, 1'b0, '{24'd0, 1'b0}},
      '{'{24'd100, 24'd200, 24'd50, 24'd60, 16'd0}, 1'b1, '{24'd50, 1'b0}},
      '{'{24'd77, 24'd77, 24'd77, 24'd77, 16'd0}, 1'b1, '{24'd77, 1'b0}},
      '{'{24'hFFFF00, DIST_INF, DIST_INF, DIST_INF, 16'hFFFF}, 1'b1, '{DIST_MAX_FIN, 1'b0}},
      '{'{24'd1000, 24'd900, 24'd2000, 24'd800, 16'd500}, 1'b0, '{24'd0, 1'b0}},
      '{'{24'h123456, 24'h654321, 24'hABCDEF, 24'h0FEDCB, 16'hA5A5}, 1'b0, '{24'd0, 1'b0}},
      '{'{DIST_INF, DIST_INF, 24'd0, DIST_INF, 16'd0}, 1'b1, '{24'd0, 1'b0}},
      '{'{24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 16'h5555}, 1'b0, '{24'd0, 1'b0}},
      '{'{24'd3, DIST_INF, DIST_INF, 24'd4, 16'd1}, 1'b0, '{24'd0, 1'b0}}
   };

   eikonal_local_update DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_dist_left    (req_dist_left),
      .req_dist_right   (req_dist_right),
      .req_dist_up      (req_dist_up),
      .req_dist_down    (req_dist_down),
      .req_local_cost   (req_local_cost),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_new_distance (rsp_new_distance),
      .rsp_unreachable  (rsp_unreachable)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_arrivals.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] root, trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic arrival_type arrival_model(input pixel_type px,
                                                 output route_type route);
      logic [63:0] a, b, lo, c, gap, twocc, sq, res;
      arrival_type nd;
      a  = (px.left < px.right) ? 64'(px.left) : 64'(px.right);
      b  = (px.up < px.down) ? 64'(px.up) : 64'(px.down);
      lo = (a < b) ? a : b;
      c  = 64'(px.cost);
      nd.unreachable = 1'b0;
      if (a == 64'(DIST_INF) && b == 64'(DIST_INF)) begin
         nd.distance    = DIST_INF;
         nd.unreachable = 1'b1;
         route          = ROUTE_BLOCKED;
         return nd;
      end
      gap   = (a > b) ? a - b : b - a;
      twocc = (c * c) << 1;
      sq    = gap * gap;
      if (a == 64'(DIST_INF) || b == 64'(DIST_INF) || sq > twocc) begin
         res   = lo + c;
         route = ROUTE_ONE_SIDED;
      end else begin
         res   = (a + b + floor_sqrt(twocc - sq)) >> 1;
         route = ROUTE_TWO_SIDED;
      end
      nd.distance = (res >= 64'(DIST_INF)) ? DIST_MAX_FIN : res[DIST_W-1:0];
      return nd;
   endfunction

   function automatic dist_type near_dist(input logic [63:0] base, input logic [63:0] spread);
      logic [63:0] v;
      if ($urandom_range(0, 7) == 0) return DIST_INF;
      v = base + 64'($urandom_range(0, spread[31:0]));
      return (v >= 64'(DIST_INF)) ? DIST_INF : v[DIST_W-1:0];
   endfunction

   // mostly neighbours clustered within reach of the cost, so the quadratic path is hit
   function automatic pixel_type random_pixel();
      pixel_type   px;
      logic [63:0] base, spread;
      int          shape;
      shape   = $urandom_range(0, 9);
      px.cost = ($urandom_range(0, 1) == 0) ? COST_W'($urandom)
                                            : COST_W'($urandom_range(0, 'h1FF));
      spread  = (64'(px.cost) << 1) + 64'd2;
      if (shape == 7)
         base = 64'(DIST_INF) - 64'($urandom_range(0, 'h20000));
      else
         base = 64'($urandom_range(0, 32'(DIST_INF)));
      px.left  = near_dist(base, spread);
      px.right = near_dist(base, spread);
      px.up    = near_dist(base, spread);
      px.down  = near_dist(base, spread);
      case (shape)
         0, 1: begin
            px.left  = DIST_W'($urandom);
            px.right = DIST_W'($urandom);
            px.up    = DIST_W'($urandom);
            px.down  = DIST_W'($urandom);
         end
         8: begin
            if ($urandom_range(0, 1) == 0) begin
               px.left  = DIST_INF;
               px.right = DIST_INF;
            end else begin
               px.up   = DIST_INF;
               px.down = DIST_INF;
            end
         end
         9: begin
            px.left  = DIST_INF;
            px.right = DIST_INF;
            px.up    = DIST_INF;
            px.down  = DIST_INF;
         end
         default: ;
      endcase
      return px;
   endfunction

   task automatic offer_pixel(input pixel_type px, input logic known,
                              input arrival_type want);
      int          pause;
      route_type   route;
      arrival_type predicted;
      pause = tx_calm ? 0 : $urandom_range(0, 11);
      if (pause != 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_dist_left  <= px.left;
      req_dist_right <= px.right;
      req_dist_up    <= px.up;
      req_dist_down  <= px.down;
      req_local_cost <= px.cost;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = arrival_model(px, route);
      route_count[route]++;
      pending_arrivals.push_back(known ? want : predicted);
      sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_arrivals.size() != 0);
   endtask

   initial begin : consumer
      int pause, served;
      bit calm;
      served = 0;
      calm   = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (served % 48 == 0) calm = ($urandom_range(0, 2) == 0);
         if (hold_request) begin
            pause        = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            pause = calm ? 0 : $urandom_range(0, 11);
         end
         rsp_stall <= (pause != 0);
         if (pause != 0) begin
            repeat (pause) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         served++;
      end
   end

   always @(posedge clock) begin : result_checker
      arrival_type want;
      if (!reset && req_valid && req_stall === 1'b1) held_cycles++;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_arrivals.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected item, expected none, got dist %h unreachable %b",
                     $time, rsp_new_distance, rsp_unreachable);
         end else begin
            want = pending_arrivals.pop_front();
            received++;
            if (rsp_new_distance !== want.distance) begin
               mismatches++;
               $display("%0t: new_distance expected %h got %h",
                        $time, want.distance, rsp_new_distance);
            end
            if (rsp_unreachable !== want.unreachable) begin
               mismatches++;
               $display("%0t: unreachable expected %b got %b",
                        $time, want.unreachable, rsp_unreachable);
            end
         end
      end
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      tx_calm = 1'b0;
      for (int p = 0; p < NUM_PROBES; p++)
         offer_pixel(probe_table[p].px, probe_table[p].known, probe_table[p].want);
      drain_results();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
         if (i == 300) hold_request = 1'b1;
         if (i >= 300 && i < 400) tx_calm = 1'b1;
         if (i == 800) drain_results();
         offer_pixel(random_pixel(), 1'b0, '0);
      end
      drain_results();
      repeat (NUM_STAGES + 5) @(posedge clock);
      $display("Sent %0d pixel updates (%0d directed): %0d one-sided, %0d two-sided, %0d blocked.",
               sent, NUM_PROBES, route_count[ROUTE_ONE_SIDED], route_count[ROUTE_TWO_SIDED],
               route_count[ROUTE_BLOCKED]);
      $display("Input held off for %0d cycles; %0d results checked, %0d mismatches.",
               held_cycles, received, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
